### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the polynomial multiplier
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define PM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is low
`define PM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### src/pm_pkg.sv
// ----------------------------------------------------------------------------
// pm_pkg
// types and constants shared by the polynomial multiplier modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pm_pkg;

    localparam int MAX_TERMS_DEF  = 32;
    localparam int COEFF_BITS_DEF = 32;
    localparam int SAT_W          = 72;

    typedef enum logic [1:0] {
        CMD_LOAD_FIRST  = 2'd0,
        CMD_LOAD_SECOND = 2'd1,
        CMD_COMPUTE     = 2'd2,
        CMD_UNUSED      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // control broadcast along the cell chain
    typedef struct packed {
        logic adv;
        logic x_use;
    } t_chain_ctl;

endpackage

### src/pm_cell.sv
// ----------------------------------------------------------------------------
// pm_cell
// one tap: holds a first-polynomial coefficient, multiplies it by the
// broadcast term and adds the product to the partial sum from its neighbour
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pm_cell #(
    parameter int COEFF_BITS = 32,
    parameter int ACC_W      = 70
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pm_pkg::t_chain_ctl     i_ctl,
    input  logic                   i_en,
    input  logic                   i_wr,
    input  logic [COEFF_BITS-1:0]  i_wr_value,
    input  logic [COEFF_BITS-1:0]  i_x,
    input  logic [ACC_W-1:0]       i_acc,
    output logic [ACC_W-1:0]       o_acc
);
    import pm_pkg::*;

    localparam int PROD_W = 2 * COEFF_BITS;

    logic        [COEFF_BITS-1:0] r_coeff;
    logic signed [PROD_W-1:0]     r_prod;
    logic        [ACC_W-1:0]      r_acc;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_coeff <= i_wr_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod <= '0;
            r_acc  <= '0;
        end else if (i_ctl.adv) begin
            if (i_en && i_ctl.x_use) begin
                r_prod <= $signed(r_coeff) * $signed(i_x);
            end else begin
                r_prod <= '0;
            end
            r_acc <= i_acc + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;

endmodule

### src/pm_chain.sv
// ----------------------------------------------------------------------------
// pm_chain
// row of taps in transposed form; partial sums move one cell towards
// cell zero every step, whose sum is the finished product coefficient
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pm_chain #(
    parameter int MAX_TERMS  = 32,
    parameter int COEFF_BITS = 32,
    parameter int ADDR_W     = 5,
    parameter int CNT_W      = 6,
    parameter int ACC_W      = 70
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pm_pkg::t_chain_ctl     i_ctl,
    input  logic [CNT_W-1:0]       i_count,
    input  logic                   i_wr,
    input  logic [ADDR_W-1:0]      i_wr_idx,
    input  logic [COEFF_BITS-1:0]  i_wr_value,
    input  logic [COEFF_BITS-1:0]  i_x,
    output logic [ACC_W-1:0]       o_acc
);
    import pm_pkg::*;

    logic [ACC_W-1:0] w_acc [MAX_TERMS+1];

    assign w_acc[MAX_TERMS] = '0;

    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
        logic w_en;
        logic w_wr;

        // taps at or above the loaded length contribute nothing
        assign w_en = (CNT_W'(g) < i_count);
        assign w_wr = i_wr && (i_wr_idx == ADDR_W'(g));

        pm_cell #(
            .COEFF_BITS (COEFF_BITS),
            .ACC_W      (ACC_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_en       (w_en),
            .i_wr       (w_wr),
            .i_wr_value (i_wr_value),
            .i_x        (i_x),
            .i_acc      (w_acc[g+1]),
            .o_acc      (w_acc[g])
        );
    end

    assign o_acc = w_acc[0];

endmodule

### src/polynomial_multiply_core.sv
// ----------------------------------------------------------------------------
// polynomial_multiply_core
// product of two loaded polynomials on a chain of multiply-accumulate taps
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready) carries load and compute requests.
//   load requests: cmd 0 writes the first polynomial into the tap chain, cmd 1
//   writes the second into a local memory. last_coeff ends a polynomial; the
//   following load starts it over. a compute request streams the second
//   polynomial past the taps, one term per cycle unless the output stalls, and
//   yields la+lb-1 results on the output channel (o_out_valid / i_out_ready),
//   lowest power first, the last one marked. each term passes the operand
//   register, the tap product and sum registers and the output register;
//   results leave one per cycle while taken, and the input stays blocked until
//   the last result is in the output register. a stalled receiver freezes the
//   whole chain until the output register is taken; nothing is lost. loads are
//   accepted while a result waits. reset clears counts, flags and the chain
//   sums; stores need no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module polynomial_multiply_core #(
    parameter int MAX_TERMS  = pm_pkg::MAX_TERMS_DEF,
    parameter int COEFF_BITS = pm_pkg::COEFF_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_coeff_value,
    input  logic               i_last_coeff,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [63:0] o_product_value,
    output logic [5:0]         o_term_index,
    output logic               o_last_term,
    output logic               o_truncated,
    output logic               o_saturated
);
    import pm_pkg::*;

    localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W  = $clog2(MAX_TERMS + 1);
    localparam int STEP_W = $clog2(2 * MAX_TERMS);
    localparam int ACC_W  = 2 * COEFF_BITS + $clog2(MAX_TERMS) + 1;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_first_count, r_second_count;
    logic                r_first_done, r_second_done;
    logic                r_drop;
    logic [STEP_W-1:0]   r_step, r_last_idx, r_lb;

    logic [COEFF_BITS-1:0] r_second_mem [MAX_TERMS];
    logic [COEFF_BITS-1:0] r_bq;

    // per-stage request tags
    logic                r_t1_vld, r_t1_useb, r_t1_last;
    logic [STEP_W-1:0]   r_t1_idx;
    logic                r_t2_vld, r_t2_last;
    logic [STEP_W-1:0]   r_t2_idx;
    logic                r_t3_vld, r_t3_last;
    logic [STEP_W-1:0]   r_t3_idx;

    logic                w_accept, w_adv, w_issue;
    logic                w_load_a, w_load_b, w_compute;
    logic [COEFF_BITS-1:0] w_coeff;
    logic [CNT_W-1:0]    w_a_base, w_b_base;
    logic                w_a_room, w_b_room;
    logic [CNT_W-1:0]    w_la_eff, w_lb_eff;
    t_chain_ctl          w_ctl;
    logic [ACC_W-1:0]    w_acc0;
    logic signed [SAT_W-1:0] w_wide;
    logic                w_in_range;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load_a   = w_accept && (t_cmd'(i_cmd) == CMD_LOAD_FIRST);
    assign w_load_b   = w_accept && (t_cmd'(i_cmd) == CMD_LOAD_SECOND);
    assign w_compute  = w_accept && (t_cmd'(i_cmd) == CMD_COMPUTE);
    assign w_coeff    = i_coeff_value[COEFF_BITS-1:0];
    assign w_adv      = !o_out_valid || i_out_ready;

    // a finished polynomial restarts on its next load
    assign w_a_base = r_first_done  ? '0 : r_first_count;
    assign w_b_base = r_second_done ? '0 : r_second_count;
    assign w_a_room = (w_a_base < CNT_W'(MAX_TERMS));
    assign w_b_room = (w_b_base < CNT_W'(MAX_TERMS));

    // an empty polynomial is the zero polynomial of length one
    assign w_la_eff = (r_first_count  == '0) ? CNT_W'(1) : r_first_count;
    assign w_lb_eff = (r_second_count == '0) ? CNT_W'(1) : r_second_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_count  <= '0;
            r_second_count <= '0;
            r_first_done   <= 1'b0;
            r_second_done  <= 1'b0;
            r_drop         <= 1'b0;
        end else begin
            if (w_load_a) begin
                r_first_count <= w_a_room ? w_a_base + CNT_W'(1) : w_a_base;
                r_first_done  <= i_last_coeff;
                if (!w_a_room) begin
                    r_drop <= 1'b1;
                end
            end
            if (w_load_b) begin
                r_second_count <= w_b_room ? w_b_base + CNT_W'(1) : w_b_base;
                r_second_done  <= i_last_coeff;
                if (!w_b_room) begin
                    r_drop <= 1'b1;
                end
            end
        end
    end

    // second polynomial store
    always_ff @(posedge i_clk) begin
        if (w_load_b && w_b_room) begin
            r_second_mem[w_b_base[ADDR_W-1:0]] <= w_coeff;
        end
        if (w_adv) begin
            r_bq <= r_second_mem[r_step[ADDR_W-1:0]];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_issue = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_compute) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                w_issue = w_adv;
                if (w_adv && (r_step == r_last_idx)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_adv && r_t3_vld && r_t3_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_compute) begin
            r_step     <= '0;
            r_lb       <= STEP_W'(r_second_count);
            r_last_idx <= STEP_W'(w_la_eff) + STEP_W'(w_lb_eff) - STEP_W'(2);
        end else if (w_issue) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_vld <= 1'b0;
            r_t2_vld <= 1'b0;
            r_t3_vld <= 1'b0;
        end else if (w_adv) begin
            r_t1_vld <= w_issue;
            r_t2_vld <= r_t1_vld;
            r_t3_vld <= r_t2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t1_useb <= w_issue && (r_step < r_lb);
            r_t1_idx  <= r_step;
            r_t1_last <= (r_step == r_last_idx);
            r_t2_idx  <= r_t1_idx;
            r_t2_last <= r_t1_last;
            r_t3_idx  <= r_t2_idx;
            r_t3_last <= r_t2_last;
        end
    end

    assign w_ctl.adv   = w_adv;
    assign w_ctl.x_use = r_t1_vld && r_t1_useb;

    pm_chain #(
        .MAX_TERMS  (MAX_TERMS),
        .COEFF_BITS (COEFF_BITS),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W),
        .ACC_W      (ACC_W)
    ) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_count    (r_first_count),
        .i_wr       (w_load_a && w_a_room),
        .i_wr_idx   (w_a_base[ADDR_W-1:0]),
        .i_wr_value (w_coeff),
        .i_x        (r_bq),
        .o_acc      (w_acc0)
    );

    // saturate the exact sum to the 64-bit range
    assign w_wide     = SAT_W'($signed(w_acc0));
    assign w_in_range = (&w_wide[SAT_W-1:63]) || !(|w_wide[SAT_W-1:63]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            o_out_valid <= r_t3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_t3_vld) begin
            if (w_in_range) begin
                o_product_value <= w_wide[63:0];
            end else if (w_wide[SAT_W-1]) begin
                o_product_value <= {1'b1, 63'd0};
            end else begin
                o_product_value <= {1'b0, {63{1'b1}}};
            end
            o_saturated  <= !w_in_range;
            o_term_index <= 6'(r_t3_idx);
            o_last_term  <= r_t3_last;
            o_truncated  <= r_drop;
        end
    end

    `PM_ASSERT_NXT(a_compute_blocks, i_clk, i_rst_n, w_compute, !o_in_ready)
    `PM_ASSERT_IMP(a_sat_value, i_clk, i_rst_n, o_out_valid && o_saturated,
        (o_product_value == {1'b1, 63'd0}) || (o_product_value == {1'b0, {63{1'b1}}}))
    `PM_ASSERT_IMP(a_step_bound, i_clk, i_rst_n, r_state == ST_RUN, r_step <= r_last_idx)

endmodule
